// ----- src/rse_pkg.sv -----
// Shared types, constants and the GF multiply for the Reed-Solomon encoder.
`default_nettype none
package rse_pkg;

  // Symbol width and the largest number of parity symbols.
  localparam int unsigned SymBits   = 8;
  localparam int unsigned ParityMax = 16;
  localparam int unsigned CntW      = $clog2(ParityMax);
  localparam int unsigned TW        = $clog2(ParityMax + 1);

  // Configuration port widths.
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 64;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegFieldPoly   = 4'd0;
  localparam logic [CfgIdxW-1:0] RegParityCount = 4'd1;
  localparam logic [CfgIdxW-1:0] RegGenLow      = 4'd2;
  localparam logic [CfgIdxW-1:0] RegGenHigh     = 4'd3;

  // Parity count limits.
  localparam logic [TW-1:0] TMin = TW'(2);
  localparam logic [TW-1:0] TMax = TW'(ParityMax);

  typedef logic [SymBits-1:0] sym_t;
  typedef logic [ParityMax-1:0][SymBits-1:0] sym_vec_t;

  // Decoded configuration seen by the datapath.
  typedef struct packed {
    sym_t          poly;   // low bits of the field polynomial
    logic [TW-1:0] t;      // parity count, saturated into range
    sym_vec_t      coeff;  // coeff[k] holds g(k+1)
  } rse_cfg_t;

  // One queued information item.
  typedef struct packed {
    logic valid;
    sym_t sym;
    logic last;
  } rse_qitem_t;

  // Shift-and-add multiply modulo x^SymBits + poly.
  function automatic sym_t gf_mul(sym_t a, sym_t b, sym_t poly);
    sym_t r;
    sym_t aa;
    logic carry;
    r  = '0;
    aa = a;
    for (int i = 0; i < SymBits; i++) begin
      if (b[i]) r = r ^ aa;
      carry = aa[SymBits-1];
      aa    = {aa[SymBits-2:0], 1'b0};
      if (carry) aa = aa ^ poly;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/rse_cfg.sv -----
// Configuration registers and their decoding for the encoder datapath.
`default_nettype none
module rse_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output      logic                         cfg_ready_o,
  input  wire logic [rse_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [rse_pkg::CfgDataW-1:0] cfg_data_i,
  output      rse_pkg::rse_cfg_t            cfg_o
);
  import rse_pkg::*;

  logic [7:0]          poly_q;
  logic [4:0]          pcount_q;
  logic [CfgDataW-1:0] gen_lo_q;
  logic [CfgDataW-1:0] gen_hi_q;

  assign cfg_ready_o = 1'b1;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q   <= 8'd29;
      pcount_q <= 5'd16;
      gen_lo_q <= '0;
      gen_hi_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegFieldPoly:   poly_q   <= cfg_data_i[7:0];
        RegParityCount: pcount_q <= cfg_data_i[4:0];
        RegGenLow:      gen_lo_q <= cfg_data_i;
        RegGenHigh:     gen_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Saturate T and unpack the coefficient bytes
  always_comb begin
    cfg_o.poly = poly_q[SymBits-1:0];
    if (TW'(pcount_q) < TMin) begin
      cfg_o.t = TMin;
    end else if (TW'(pcount_q) > TMax) begin
      cfg_o.t = TMax;
    end else begin
      cfg_o.t = TW'(pcount_q);
    end
    cfg_o.coeff = {gen_hi_q, gen_lo_q};
  end

endmodule
`default_nettype wire

// ----- src/rse_front.sv -----
// Input side: takes information items and queues them for the parity engine.
`default_nettype none
module rse_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire rse_pkg::sym_t       info_symbol_i,
  input  wire logic                last_info_i,
  output      rse_pkg::rse_qitem_t item_o,
  input  wire logic                pop_i
);
  import rse_pkg::*;

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  typedef struct packed {
    sym_t sym;
    logic last;
  } entry_t;

  entry_t              mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]       count_q, count_d;
  logic                push;

  assign in_ready_o = (count_q != (PtrW+1)'(Depth));
  assign push       = in_valid_i && in_ready_o;

  assign item_o.valid = (count_q != '0);
  assign item_o.sym   = mem_q[rd_ptr_q].sym;
  assign item_o.last  = mem_q[rd_ptr_q].last;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push  ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop_i) count_d = count_q + 1'b1;
    if (!push && pop_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q].sym  <= info_symbol_i;
      mem_q[wr_ptr_q].last <= last_info_i;
    end
  end

endmodule
`default_nettype wire

// ----- src/rse_back.sv -----
// Parity engine: shift register update, parity drain and the output register.
`default_nettype none
module rse_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire rse_pkg::rse_cfg_t   cfg_i,
  input  wire rse_pkg::rse_qitem_t item_i,
  output      logic                pop_o,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      rse_pkg::sym_t       code_symbol_o,
  output      logic                is_parity_o,
  output      logic                last_o
);
  import rse_pkg::*;

  sym_vec_t        store_q, store_d;
  sym_vec_t        upd;
  sym_vec_t        shifted;
  sym_t            fb;
  logic            drain_q, drain_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  sym_t            code_q, code_d;
  logic            par_q, par_d;
  logic            last_q, last_d;
  logic            can_load;
  logic [TW-1:0]   t_m1;
  logic            final_par;

  assign can_load  = !out_valid_q || out_ready_i;
  assign pop_o     = !drain_q && item_i.valid && can_load;
  assign t_m1      = cfg_i.t - 1'b1;
  assign final_par = (TW'(cnt_q) == t_m1);
  assign shifted   = store_q >> SymBits;

  // Parallel register update for one information symbol
  always_comb begin
    fb = item_i.sym ^ store_q[0];
    for (int j = 0; j < ParityMax; j++) begin
      if (TW'(j) < t_m1) begin
        upd[j] = shifted[j] ^ gf_mul(fb, cfg_i.coeff[j], cfg_i.poly);
      end else if (TW'(j) == t_m1) begin
        upd[j] = gf_mul(fb, cfg_i.coeff[j], cfg_i.poly);
      end else begin
        upd[j] = store_q[j];
      end
    end
  end

  // Choose what goes into the output register
  always_comb begin
    store_d     = store_q;
    drain_d     = drain_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    code_d      = code_q;
    par_d       = par_q;
    last_d      = last_q;
    if (can_load) begin
      out_valid_d = 1'b0;
      if (pop_o) begin
        store_d     = upd;
        out_valid_d = 1'b1;
        code_d      = item_i.sym;
        par_d       = 1'b0;
        last_d      = 1'b0;
        if (item_i.last) begin
          drain_d = 1'b1;
          cnt_d   = '0;
        end
      end else if (drain_q) begin
        out_valid_d = 1'b1;
        code_d      = store_q[0];
        par_d       = 1'b1;
        last_d      = final_par;
        store_d     = shifted;
        if (final_par) begin
          store_d = '0;
          drain_d = 1'b0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q     <= '0;
      drain_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      store_q     <= store_d;
      drain_q     <= drain_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    par_q  <= par_d;
    last_q <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign code_symbol_o = code_q;
  assign is_parity_o   = par_q;
  assign last_o        = last_q;

endmodule
`default_nettype wire

// ----- src/rs_systematic_encoder_unit.sv -----
// Top level of the systematic Reed-Solomon encoder.
// Takes one information symbol per cycle while the input queue has room and
// passes it through while the parity shift register updates all T positions
// in parallel; after the item marked last_info it emits the T parity symbols,
// one per cycle unless the output stalls, the final one marked by last_o.
// Unstalled, the rate is one item per cycle plus each codeword's parity drain;
// during the drain the four-entry input queue keeps taking items until full.
// Items pass the queue, then the output register. Configuration is to be
// written only while idle, unenforced by the block; cfg_ready_o is always high.
`default_nettype none
module rs_systematic_encoder_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output      logic                         cfg_ready_o,
  input  wire logic [rse_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [rse_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire logic [7:0]                   info_symbol_i,
  input  wire logic                         last_info_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic [7:0]                   code_symbol_o,
  output      logic                         is_parity_o,
  output      logic                         last_o
);
  import rse_pkg::*;

  rse_cfg_t   cfg;
  rse_qitem_t item;
  logic       pop;

  rse_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rse_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .info_symbol_i (info_symbol_i),
    .last_info_i   (last_info_i),
    .item_o        (item),
    .pop_i         (pop)
  );

  rse_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .item_i        (item),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .code_symbol_o (code_symbol_o),
    .is_parity_o   (is_parity_o),
    .last_o        (last_o)
  );

endmodule
`default_nettype wire

// ----- src/rse_checker.sv -----
// Port-level checks on the encoder output sequence, bound to the top level.
`default_nettype none
module rse_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] code_symbol_o,
  input wire logic       is_parity_o,
  input wire logic       last_o
);

  // A stalled output item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(code_symbol_o)
      && $stable(is_parity_o) && $stable(last_o))
    else $error("output item changed while stalled");

  // The codeword end marker only sits on a parity symbol
  a_last_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> is_parity_o)
    else $error("last marker on an information symbol");

  // Parity drain runs without gaps until the final parity symbol
  a_drain_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && is_parity_o && !last_o |=>
      out_valid_o && is_parity_o)
    else $error("gap or information symbol inside parity drain");

  // No parity symbol follows the final one
  a_drain_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_o |=> !(out_valid_o && is_parity_o))
    else $error("parity symbol after end of codeword");

endmodule

bind rs_systematic_encoder_unit rse_checker u_rse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .code_symbol_o (code_symbol_o),
  .is_parity_o   (is_parity_o),
  .last_o        (last_o)
);
`default_nettype wire
